// ===== design/rational_add_sub_reduce_unit_defines.svh =====
// assertion macros for the rational add/sub/reduce unit
// used by the controller; expects signals clk and rst in scope
`ifndef RATIONAL_ADD_SUB_REDUCE_UNIT_DEFINES_SVH
`define RATIONAL_ADD_SUB_REDUCE_UNIT_DEFINES_SVH

// same-cycle implication
`define RASR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RASR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rasr_pkg.sv =====
// shared types and codes for the rational add/sub/reduce unit
// no dependencies
package rasr_pkg;

  localparam int FIELD_W = 32;
  localparam int DEN_W   = 31;

  // commands
  localparam logic [1:0] CMD_NORM = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_SUB  = 2'd2;
  localparam logic [1:0] CMD_EQ   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // multiplier operand selection
  localparam logic [1:0] MUL_AD  = 2'd0;
  localparam logic [1:0] MUL_BC  = 2'd1;
  localparam logic [1:0] MUL_DEN = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sum;
    logic       gcd_init;
    logic       twos_step;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } rasr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       zero_den;
    logic       twos_done;
    logic       gcd_done;
    logic       div_done;
  } rasr_stat_t;

endpackage

// ===== design/rasr_dp.sv =====
// datapath: operand capture, shared multiplier, binary gcd, two restoring dividers
// depends on rasr_pkg
module rasr_dp import rasr_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rasr_cmd_t           cmd,
  output rasr_stat_t          stat,
  input  logic [1:0]          in_cmd,
  input  logic [FIELD_W-1:0]  in_ln,
  input  logic [FIELD_W-1:0]  in_ld,
  input  logic [FIELD_W-1:0]  in_rn,
  input  logic [FIELD_W-1:0]  in_rd,
  output logic [FIELD_W-1:0]  result_num,
  output logic [DEN_W-1:0]    result_den,
  output logic                is_equal,
  output logic [1:0]          status
);

  localparam int W  = DATA_WIDTH;
  localparam int MW = 2 * DATA_WIDTH;
  localparam int KW = $clog2(MW);
  localparam int CW = $clog2(MW + 1);
  localparam logic [MW-1:0] LIM = (MW'(1) << (W - 1)) - MW'(1);

  // operand registers, sign and magnitude
  logic [1:0]    op_cmd;
  logic [W-1:0]  lnm, ldm, rnm, rdm;
  logic          lns, lds, rns, rds;
  logic          eq_flag, zden;

  // fraction under reduction
  logic [MW-1:0] nmag, dmag;
  logic          nneg, dneg;
  logic [MW-1:0] pa, pb;

  // gcd and divider state
  logic [MW-1:0] ga, gb, gdiv;
  logic [KW-1:0] k;
  logic [MW-1:0] xn, xd, remn, remd;
  logic [CW-1:0] cnt;

  function automatic logic [W:0] to_sm(input logic [FIELD_W-1:0] v);
    logic [W-1:0] x;
    logic         s;
    x = v[W-1:0];
    s = x[W-1];
    to_sm = {s, s ? (~x + W'(1)) : x};
  endfunction

  logic [W:0] sm_ln, sm_ld, sm_rn, sm_rd;
  assign sm_ln = to_sm(in_ln);
  assign sm_ld = to_sm(in_ld);
  assign sm_rn = to_sm(in_rn);
  assign sm_rd = to_sm(in_rd);

  // shared multiplier
  logic [W-1:0]  mul_a, mul_b;
  logic [MW-1:0] prod;
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_AD:  begin mul_a = lnm; mul_b = rdm; end
      MUL_BC:  begin mul_a = rnm; mul_b = ldm; end
      default: begin mul_a = ldm; mul_b = rdm; end
    endcase
  end
  assign prod = MW'(mul_a) * MW'(mul_b);

  // signed add of the two cross products
  logic          a_neg, b_neg, b_neg0, s_neg;
  logic [MW-1:0] s_mag;
  always_comb begin
    a_neg  = (pa != '0) && (lns != rds);
    b_neg0 = (pb != '0) && (rns != lds);
    b_neg  = (op_cmd == CMD_SUB && pb != '0) ? !b_neg0 : b_neg0;
    if (a_neg == b_neg) begin
      s_mag = pa + pb;
      s_neg = a_neg;
    end else if (pa >= pb) begin
      s_mag = pa - pb;
      s_neg = a_neg;
    end else begin
      s_mag = pb - pa;
      s_neg = b_neg;
    end
    if (s_mag == '0) s_neg = 1'b0;
  end

  // divider step
  logic [MW:0] tn, td;
  logic        gen, ged;
  always_comb begin
    tn  = {remn, xn[MW-1]};
    td  = {remd, xd[MW-1]};
    gen = tn >= {1'b0, gdiv};
    ged = td >= {1'b0, gdiv};
  end

  logic can_twos;
  assign can_twos = (ga != '0) && !ga[0] && !gb[0];

  // final result
  logic          r_neg, r_ovf;
  logic [FIELD_W-1:0] qn32;
  always_comb begin
    r_neg = (xn != '0) && (nneg != dneg);
    r_ovf = (xd > LIM) || (xn > (LIM + MW'(r_neg)));
    qn32  = FIELD_W'(xn);
  end

  // operand capture and arithmetic sequence
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_cmd  <= in_cmd;
      {lns, lnm} <= sm_ln;
      {lds, ldm} <= sm_ld;
      {rns, rnm} <= sm_rn;
      {rds, rdm} <= sm_rd;
      eq_flag <= (in_ln[W-1:0] == in_rn[W-1:0]) && (in_ld[W-1:0] == in_rd[W-1:0]);
      zden    <= (in_cmd == CMD_NORM) ? (in_ld[W-1:0] == '0)
                 : ((in_ld[W-1:0] == '0) || (in_rd[W-1:0] == '0));
      nmag    <= MW'(sm_ln[W-1:0]);
      nneg    <= sm_ln[W] && (sm_ln[W-1:0] != '0);
      dmag    <= MW'(sm_ld[W-1:0]);
      dneg    <= sm_ld[W];
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_AD:  pa <= prod;
        MUL_BC:  pb <= prod;
        default: dmag <= prod;
      endcase
    end
    if (cmd.sum) begin
      nmag <= s_mag;
      nneg <= s_neg;
      dneg <= lds != rds;
    end
    if (cmd.gcd_init) begin
      ga <= nmag;
      gb <= dmag;
      k  <= '0;
    end
    if (cmd.twos_step && can_twos) begin
      ga <= ga >> 1;
      gb <= gb >> 1;
      k  <= k + KW'(1);
    end
    if (cmd.gcd_step && ga != '0) begin
      if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end
    if (cmd.div_init) begin
      gdiv <= gb << k;
      xn   <= nmag;
      xd   <= dmag;
      remn <= '0;
      remd <= '0;
    end
    if (cmd.div_step) begin
      remn <= gen ? MW'(tn - {1'b0, gdiv}) : tn[MW-1:0];
      remd <= ged ? MW'(td - {1'b0, gdiv}) : td[MW-1:0];
      xn   <= {xn[MW-2:0], gen};
      xd   <= {xd[MW-2:0], ged};
    end
    if (cmd.out_load) begin
      result_num <= '0;
      result_den <= '0;
      is_equal   <= 1'b0;
      status     <= ST_OK;
      if (op_cmd == CMD_EQ) begin
        is_equal <= eq_flag;
      end else if (zden) begin
        status <= ST_ZERO_DEN;
      end else if (r_ovf) begin
        status <= ST_OVERFLOW;
      end else begin
        result_num <= r_neg ? (~qn32 + FIELD_W'(1)) : qn32;
        result_den <= DEN_W'(xd);
      end
    end
  end

  // divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_init) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CW'(1);
    end
  end

  assign stat.cmd       = op_cmd;
  assign stat.zero_den  = zden;
  assign stat.twos_done = !can_twos;
  assign stat.gcd_done  = ga == '0;
  assign stat.div_done  = cnt == CW'(MW);

endmodule

// ===== design/rasr_ctrl.sv =====
// controller: sequences load, multiply, add, gcd, divide and result hand-off
// depends on rasr_pkg and rational_add_sub_reduce_unit_defines.svh
`include "rational_add_sub_reduce_unit_defines.svh"
module rasr_ctrl import rasr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output rasr_cmd_t  cmd,
  input  rasr_stat_t stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MUL0  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_GINIT = 4'd6;
  localparam logic [3:0] S_TWOS  = 4'd7;
  localparam logic [3:0] S_GCD   = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state, state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.cmd == CMD_EQ || stat.zero_den) begin
          state_next = S_FIN;
        end else if (stat.cmd == CMD_NORM) begin
          state_next = S_GINIT;
        end else begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_AD;  state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_BC;  state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DEN; state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1; state_next = S_GINIT;
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1; state_next = S_TWOS;
      end
      S_TWOS: begin
        cmd.twos_step = 1'b1;
        if (stat.twos_done) state_next = S_GCD;
      end
      S_GCD: begin
        cmd.gcd_step = 1'b1;
        if (stat.gcd_done) state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1; state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `RASR_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state == S_DISP, "accept must start work")
  `RASR_ASSERT_NOW(a_load_free, cmd.out_load, out_free, "result loaded over a pending one")
  `RASR_ASSERT_NEXT(a_div_fin, state == S_DIV && stat.div_done, state == S_FIN, "divide end lost")
  `RASR_ASSERT_NOW(a_valid_src, $rose(m_tvalid), $past(state) == S_FIN, "result valid without finish")

endmodule

// ===== design/rational_add_sub_reduce_unit.sv =====
// top level of the rational add/sub/reduce unit
// depends on rasr_pkg, rasr_ctrl and rasr_dp
//
// Input channel s_*: one transaction carries a command in s_tuser and two
// signed fractions in s_tdata. Output channel m_*: one result transaction per
// input, reduced numerator and positive denominator, equality flag and status.
// Commands: normalize the left fraction, add, subtract, equality compare.
// Equal and zero-denominator items go from the dispatch state straight to
// the finish state. Add/subtract run the shared multiplier for both cross
// products and the common denominator; normalize and add/subtract then run a
// binary gcd of 2*DATA_WIDTH-bit values (one shift or subtract per cycle)
// and two restoring dividers in parallel.
// One item is in work at a time; the gcd loop and the dividers set the
// throughput.
// The result sits in an output register, so the next item is accepted while
// a stalled result waits on m_tready. Reset clears the controller and drops
// m_tvalid; no configuration.
module rational_add_sub_reduce_unit import rasr_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // left_num, left_den, right_num, right_den
  input  logic [127:0] s_tdata,
  // command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_num, result_den, is_equal, status, zero pad
  output logic [71:0]  m_tdata
);

  rasr_cmd_t          cmd;
  rasr_stat_t         stat;
  logic [FIELD_W-1:0] result_num;
  logic [DEN_W-1:0]   result_den;
  logic               is_equal;
  logic [1:0]         status;

  rasr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rasr_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (s_tuser),
    .in_ln      (s_tdata[31:0]),
    .in_ld      (s_tdata[63:32]),
    .in_rn      (s_tdata[95:64]),
    .in_rd      (s_tdata[127:96]),
    .result_num (result_num),
    .result_den (result_den),
    .is_equal   (is_equal),
    .status     (status)
  );

  assign m_tdata = {6'd0, status, is_equal, result_den, result_num};

endmodule
